@@ rtl/whole_word_paragraph_counter_unit_assert.svh @@
// Assertion macros for the whole-word paragraph counter.
`ifndef WHOLE_WORD_PARAGRAPH_COUNTER_UNIT_ASSERT_SVH
`define WHOLE_WORD_PARAGRAPH_COUNTER_UNIT_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define WWPC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WWPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wwpc_pkg.sv @@
// Types, constants and helper functions of the whole-word paragraph counter.
`timescale 1ns / 1ps
package wwpc_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CNT_W      = 32;
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WORD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 1'b1;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0] paragraph_number;
        logic [CNT_W-1:0] word_count;
        logic             is_total;
        logic             last_result;
    } result_t;

    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
               (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

@@ rtl/whole_word_paragraph_counter_unit.sv @@
// Top level of the whole-word paragraph counter.
// A result is written into the result queue when its byte is accepted.
// One byte per cycle unless stalled; the last byte of a text may queue two results.
// A four-entry result queue stalls input while fewer than two entries are free.
// rst_n clears text state, the queue and the registers (target_length to one).
`timescale 1ns / 1ps
`include "whole_word_paragraph_counter_unit_assert.svh"
module whole_word_paragraph_counter_unit #(
    parameter int MAX_WORD_LEN = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [wwpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wwpc_pkg::WORD_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [wwpc_pkg::BYTE_W-1:0]            text_byte,
    input  logic                                   last_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [wwpc_pkg::CNT_W-1:0]             paragraph_number,
    output logic [wwpc_pkg::CNT_W-1:0]             word_count,
    output logic                                   is_total,
    output logic                                   last_result
);

    localparam int WIN_DEPTH = MAX_WORD_LEN + 1;
    localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
    localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);
    localparam int TGT_IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CMP_W     = (SEEN_W > wwpc_pkg::LEN_W) ? SEEN_W : wwpc_pkg::LEN_W;
    localparam int LEN_W     = wwpc_pkg::LEN_W;
    localparam int CNT_W     = wwpc_pkg::CNT_W;

    typedef logic [WIN_DEPTH-1:0][wwpc_pkg::BYTE_W-1:0]    window_t;
    typedef logic [MAX_WORD_LEN-1:0][wwpc_pkg::BYTE_W-1:0] target_t;

    // configuration
    logic [wwpc_pkg::WORD_W-1:0] target_word_reg;
    logic [LEN_W-1:0]            target_length_reg;

    // text state
    window_t           win_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [CNT_W-1:0]  pidx_reg;
    logic [CNT_W-1:0]  pmatch_reg;
    logic [CNT_W-1:0]  total_reg;

    // result queue
    wwpc_pkg::result_t               fifo_reg [wwpc_pkg::FIFO_DEPTH];
    logic [wwpc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [wwpc_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [wwpc_pkg::FIFO_CNT_W-1:0] count_reg;

    logic              in_acc;
    logic              out_acc;
    logic [LEN_W-1:0]  len_eff;
    target_t           tgt_bytes;
    target_t           tgt_al;
    window_t           win_next;
    logic [SEEN_W-1:0] seen_next;
    logic [CNT_W-1:0]  pidx_next;
    logic [CNT_W-1:0]  pmatch_next;
    logic [CNT_W-1:0]  total_next;
    logic [1:0]        push_n;
    wwpc_pkg::result_t ent0;
    wwpc_pkg::result_t ent1;

    function automatic logic front_match(input window_t w, input logic [SEEN_W-1:0] seen,
                                         input logic [LEN_W-1:0] len, input target_t t);
        logic ok;
        ok = (CMP_W'(seen) >= CMP_W'(len));
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            if (LEN_W'(k) < len && w[k] != t[k])
            begin
                ok = 1'b0;
            end
        end
        if (CMP_W'(seen) > CMP_W'(len) && wwpc_pkg::is_letter(w[len[WIN_IDX_W-1:0]]))
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;
    assign in_stall = (count_reg > wwpc_pkg::FIFO_CNT_W'(wwpc_pkg::FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);

    assign paragraph_number = fifo_reg[rd_ptr_reg].paragraph_number;
    assign word_count       = fifo_reg[rd_ptr_reg].word_count;
    assign is_total         = fifo_reg[rd_ptr_reg].is_total;
    assign last_result      = fifo_reg[rd_ptr_reg].last_result;

    // clamp length to 1..MAX_WORD_LEN and align target so byte k faces window slot k
    always_comb
    begin
        logic [LEN_W-1:0] sel;
        if (target_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (target_length_reg > LEN_W'(MAX_WORD_LEN))
        begin
            len_eff = LEN_W'(MAX_WORD_LEN);
        end
        else
        begin
            len_eff = target_length_reg;
        end
        tgt_bytes = target_word_reg[MAX_WORD_LEN*wwpc_pkg::BYTE_W-1:0];
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            sel = len_eff - LEN_W'(1) - LEN_W'(k);
            tgt_al[k] = tgt_bytes[sel[TGT_IDX_W-1:0]];
        end
    end

    // one byte of work: pending match, paragraph close, shift, end of text
    always_comb
    begin
        logic [CNT_W-1:0] pm1;
        logic [CNT_W-1:0] tot1;
        logic [CNT_W-1:0] pm3;
        logic [CNT_W-1:0] tot3;
        logic             close;
        logic             close_emit;
        logic             para_emit;
        wwpc_pkg::result_t r_close;
        wwpc_pkg::result_t r_para;
        wwpc_pkg::result_t r_total;

        pm1  = pmatch_reg;
        tot1 = total_reg;
        if (front_match(win_reg, seen_reg, len_eff, tgt_al) && !wwpc_pkg::is_letter(text_byte))
        begin
            pm1  = wwpc_pkg::sat_inc(pmatch_reg);
            tot1 = wwpc_pkg::sat_inc(total_reg);
        end

        close = (seen_reg != '0) && (win_reg[0] == wwpc_pkg::CHAR_NEWLINE) &&
                (text_byte == wwpc_pkg::CHAR_NEWLINE);
        close_emit = close && (pm1 != '0);
        r_close = '{paragraph_number: pidx_reg, word_count: pm1,
                    is_total: 1'b0, last_result: 1'b0};
        pmatch_next = close ? '0 : pm1;
        pidx_next   = close ? wwpc_pkg::sat_inc(pidx_reg) : pidx_reg;

        win_next  = {win_reg[WIN_DEPTH-2:0], text_byte};
        seen_next = (seen_reg < SEEN_W'(WIN_DEPTH)) ? seen_reg + SEEN_W'(1) : seen_reg;

        pm3  = pmatch_next;
        tot3 = tot1;
        if (front_match(win_next, seen_next, len_eff, tgt_al))
        begin
            pm3  = wwpc_pkg::sat_inc(pmatch_next);
            tot3 = wwpc_pkg::sat_inc(tot1);
        end
        para_emit = (pm3 != '0) && !close_emit;
        r_para  = '{paragraph_number: pidx_next, word_count: pm3,
                    is_total: 1'b0, last_result: 1'b0};
        r_total = '{paragraph_number: pidx_next, word_count: tot3,
                    is_total: 1'b1, last_result: 1'b1};
        total_next = tot1;

        ent0   = r_close;
        ent1   = r_total;
        push_n = 2'd0;
        if (last_byte)
        begin
            if (close_emit || para_emit)
            begin
                ent0   = close_emit ? r_close : r_para;
                push_n = 2'd2;
            end
            else
            begin
                ent0   = r_total;
                push_n = 2'd1;
            end
        end
        else if (close_emit)
        begin
            push_n = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_word_reg   <= '0;
            target_length_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wwpc_pkg::REG_TARGET_WORD:   target_word_reg   <= cfg_data;
                wwpc_pkg::REG_TARGET_LENGTH: target_length_reg <= cfg_data[LEN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            seen_reg   <= '0;
            pidx_reg   <= CNT_W'(1);
            pmatch_reg <= '0;
            total_reg  <= '0;
        end
        else if (in_acc)
        begin
            // end of text: drop back to a fresh text
            if (last_byte)
            begin
                win_reg    <= '0;
                seen_reg   <= '0;
                pidx_reg   <= CNT_W'(1);
                pmatch_reg <= '0;
                total_reg  <= '0;
            end
            else
            begin
                win_reg    <= win_next;
                seen_reg   <= seen_next;
                pidx_reg   <= pidx_next;
                pmatch_reg <= pmatch_next;
                total_reg  <= total_next;
            end
        end
    end

    // queue payload holds no reset
    always_ff @(posedge clk)
    begin
        if (in_acc && push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= ent0;
            if (push_n == 2'd2)
            begin
                fifo_reg[wr_ptr_reg + wwpc_pkg::FIFO_PTR_W'(1)] <= ent1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            logic [wwpc_pkg::FIFO_PTR_W-1:0] push_w;
            push_w = in_acc ? wwpc_pkg::FIFO_PTR_W'(push_n) : '0;
            wr_ptr_reg <= wr_ptr_reg + push_w;
            if (out_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + wwpc_pkg::FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + wwpc_pkg::FIFO_CNT_W'(push_w)
                         - wwpc_pkg::FIFO_CNT_W'(out_acc);
        end
    end

    `WWPC_ASSERT_ALWAYS(a_fifo_bound,
        count_reg <= wwpc_pkg::FIFO_CNT_W'(wwpc_pkg::FIFO_DEPTH),
        "result queue overflow")
    `WWPC_ASSERT_NEXT(a_total_queued, in_acc && last_byte, count_reg != '0,
        "end of text queued no total beat")
    `WWPC_ASSERT_NEXT(a_text_cleared, in_acc && last_byte,
        seen_reg == '0 && pidx_reg == CNT_W'(1) && total_reg == '0,
        "text state not cleared after last byte")

endmodule

@@ tb/tb_whole_word_paragraph_counter_unit.sv @@
// Testbench for the whole-word paragraph counter: directed and random texts checked against a predictor.
`timescale 1ns / 1ps
module tb_whole_word_paragraph_counter_unit;

    localparam int          WORD_MAX    = 8;
    localparam int          WINDOW      = WORD_MAX + 1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_BYTES = 190;

    typedef struct {
        logic [wwpc_pkg::BYTE_W-1:0] b;
        logic                        last;
        bit                          drain_first;
    } text_beat_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [wwpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wwpc_pkg::WORD_W-1:0]    cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [wwpc_pkg::BYTE_W-1:0]    text_byte = '0;
    logic                           last_byte = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [wwpc_pkg::CNT_W-1:0]     paragraph_number;
    logic [wwpc_pkg::CNT_W-1:0]     word_count;
    logic                           is_total;
    logic                           last_result;

    // predictor state and register copies
    logic [wwpc_pkg::WORD_W-1:0]    target_mirror;
    logic [wwpc_pkg::LEN_W-1:0]     length_mirror;
    logic [wwpc_pkg::BYTE_W-1:0]    recent_bytes [0:WINDOW-1];
    int unsigned                    bytes_in;
    logic [wwpc_pkg::CNT_W-1:0]     para_num;
    logic [wwpc_pkg::CNT_W-1:0]     para_hits;
    logic [wwpc_pkg::CNT_W-1:0]     text_hits;

    text_beat_t                     outgoing [$];
    wwpc_pkg::result_t              expected_results [$];
    int unsigned                    mismatches = 0;
    int unsigned                    cycle_count = 0;
    int                             burst_left;
    int                             gap_left;
    bit                             hold_req = 1'b0;
    bit                             hold_seen;
    int                             hold_left;
    int                             rx_mode;
    int                             rx_mode_left;
    logic [7:0]                     rx_tick;

    whole_word_paragraph_counter_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .text_byte        (text_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .paragraph_number (paragraph_number),
        .word_count       (word_count),
        .is_total         (is_total),
        .last_result      (last_result)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit letter(input logic [wwpc_pkg::BYTE_W-1:0] b);
        return (b >= wwpc_pkg::CHAR_UPPER_A && b <= wwpc_pkg::CHAR_UPPER_Z) ||
               (b >= wwpc_pkg::CHAR_LOWER_A && b <= wwpc_pkg::CHAR_LOWER_Z);
    endfunction

    function automatic logic [wwpc_pkg::CNT_W-1:0] sat_up(
        input logic [wwpc_pkg::CNT_W-1:0] v);
        return (v == wwpc_pkg::CNT_MAX) ? v : v + wwpc_pkg::CNT_W'(1);
    endfunction

    // zero acts as one, anything past the widest word acts as the widest word
    function automatic int unsigned span_len(input logic [wwpc_pkg::LEN_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > WORD_MAX)
            return WORD_MAX;
        return r;
    endfunction

    // target ends on the newest byte, with a non-letter or text start ahead of it
    function automatic bit ends_on_target();
        int unsigned n;
        n = span_len(length_mirror);
        if (bytes_in < n)
            return 1'b0;
        for (int unsigned k = 0; k < n; k++)
            if (recent_bytes[k] != target_mirror[8*(n-1-k) +: 8])
                return 1'b0;
        if (bytes_in > n && letter(recent_bytes[n]))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic wwpc_pkg::result_t result_of(input logic [wwpc_pkg::CNT_W-1:0] num,
                                                    input logic [wwpc_pkg::CNT_W-1:0] cnt,
                                                    input logic                       total);
        wwpc_pkg::result_t r;
        r.paragraph_number = num;
        r.word_count       = cnt;
        r.is_total         = total;
        r.last_result      = total;
        return r;
    endfunction

    function automatic logic [wwpc_pkg::BYTE_W-1:0] random_letter();
        if ($urandom_range(1, 0) == 0)
            return wwpc_pkg::CHAR_UPPER_A + 8'($urandom_range(25, 0));
        return wwpc_pkg::CHAR_LOWER_A + 8'($urandom_range(25, 0));
    endfunction

    task automatic restart_text();
        for (int k = 0; k < WINDOW; k++)
            recent_bytes[k] = '0;
        bytes_in  = 0;
        para_num  = wwpc_pkg::CNT_W'(1);
        para_hits = '0;
        text_hits = '0;
    endtask

    task automatic bump_hits();
        para_hits = sat_up(para_hits);
        text_hits = sat_up(text_hits);
    endtask

    task automatic count_byte(input logic [wwpc_pkg::BYTE_W-1:0] b, input logic last);
        int n;
        n = 0;
        // a match on the previous byte is settled by this one
        if (ends_on_target() && !letter(b))
            bump_hits();
        if (bytes_in > 0 && recent_bytes[0] == wwpc_pkg::CHAR_NEWLINE &&
            b == wwpc_pkg::CHAR_NEWLINE)
        begin
            if (para_hits != 0)
            begin
                expected_results.insert(expected_results.size(),
                                        result_of(para_num, para_hits, 1'b0));
                n++;
            end
            para_hits = '0;
            para_num  = sat_up(para_num);
        end
        for (int k = WINDOW - 1; k > 0; k--)
            recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = b;
        if (bytes_in < WINDOW)
            bytes_in++;
        if (last)
        begin
            if (ends_on_target())
                bump_hits();
            // a paragraph closed on the last byte hides the final one
            if (para_hits != 0 && n == 0)
                expected_results.insert(expected_results.size(),
                                        result_of(para_num, para_hits, 1'b0));
            expected_results.insert(expected_results.size(),
                                    result_of(para_num, text_hits, 1'b1));
            restart_text();
        end
    endtask

    task automatic write_reg(input logic [wwpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wwpc_pkg::WORD_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == wwpc_pkg::REG_TARGET_WORD)
            target_mirror = val;
        else
            length_mirror = val[wwpc_pkg::LEN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_beat(input logic [wwpc_pkg::BYTE_W-1:0] b, input logic last,
                             input bit drain);
        text_beat_t beat;
        beat.b           = b;
        beat.last        = last;
        beat.drain_first = drain;
        outgoing.insert(outgoing.size(), beat);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], i == s.len() - 1, 1'b0);
    endtask

    // one text built mostly from target words and separators, with some noise
    task automatic add_text(input int unsigned max_tokens, input bit drain,
                            output int unsigned added);
        logic [wwpc_pkg::BYTE_W-1:0] text_bytes [$];
        int unsigned                 n;
        int unsigned                 tokens;
        int unsigned                 kind;
        n      = span_len(length_mirror);
        tokens = $urandom_range(max_tokens, 1);
        for (int t = 0; t < tokens; t++)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 40)
            begin
                if ($urandom_range(9, 0) == 0)
                    text_bytes = {text_bytes, random_letter()};
                for (int j = 0; j < n; j++)
                    text_bytes = {text_bytes, target_mirror[8*j +: 8]};
                if ($urandom_range(9, 0) == 0)
                    text_bytes = {text_bytes, random_letter()};
            end
            else if (kind < 60)
            begin
                case ($urandom_range(4, 0))
                    0: text_bytes = {text_bytes, 8'h20};
                    1: text_bytes = {text_bytes, 8'h2C};
                    2: text_bytes = {text_bytes, 8'h2E};
                    3: text_bytes = {text_bytes, 8'h2D};
                    default: text_bytes = {text_bytes, wwpc_pkg::CHAR_NEWLINE};
                endcase
            end
            else if (kind < 70)
                repeat ($urandom_range(3, 2)) text_bytes = {text_bytes, wwpc_pkg::CHAR_NEWLINE};
            else if (kind < 85)
                repeat ($urandom_range(6, 1)) text_bytes = {text_bytes, random_letter()};
            else if (kind < 95)
                text_bytes = {text_bytes, 8'($urandom_range(255, 0))};
            else
            begin
                // a cut-off target word
                for (int j = 0; j < $urandom_range(n, 1); j++)
                    text_bytes = {text_bytes, target_mirror[8*j +: 8]};
            end
        end
        for (int i = 0; i < text_bytes.size(); i++)
            push_beat(text_bytes[i], i == text_bytes.size() - 1, drain && i == 0);
        added = text_bytes.size();
    endtask

    task automatic wait_idle();
        while (outgoing.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // sender: bursts and gaps; a beat marked drain_first waits for all results
    always @(posedge clk or negedge rst_n)
    begin : feed
        bit offer;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            text_byte  <= '0;
            last_byte  <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                count_byte(text_byte, last_byte);
                void'(outgoing.pop_front());
            end
            // hold a stalled beat as it is
            if (!(in_valid && in_stall))
            begin
                offer = 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (outgoing.size() != 0 &&
                         !(outgoing[0].drain_first && expected_results.size() != 0))
                    offer = 1'b1;
                if (offer)
                begin
                    text_byte <= outgoing[0].b;
                    last_byte <= outgoing[0].last;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(60, 1);
                        gap_left   <= ($urandom_range(3, 0) == 0) ? $urandom_range(12, 4)
                                                                  : $urandom_range(3, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                in_valid <= offer;
            end
        end
    end

    // receiver: stall pattern of its own, plus one long hold on request
    always @(posedge clk or negedge rst_n)
    begin : sink
        bit stall_now;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_seen    <= 1'b0;
            hold_left    <= 0;
            rx_mode      <= 0;
            rx_mode_left <= 0;
            rx_tick      <= '0;
        end
        else
        begin
            stall_now = 1'b0;
            rx_tick <= rx_tick + 8'd1;
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                stall_now = 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                stall_now = 1'b1;
            end
            else
            begin
                case (rx_mode)
                    1: stall_now = ($urandom_range(2, 0) == 0);
                    2: stall_now = ($urandom_range(3, 0) != 0);
                    3: stall_now = (rx_tick[2:1] == 2'b11);
                    default: stall_now = 1'b0;
                endcase
                if (rx_mode_left == 0)
                begin
                    rx_mode      <= $urandom_range(3, 0);
                    rx_mode_left <= $urandom_range(100, 10);
                end
                else
                    rx_mode_left <= rx_mode_left - 1;
            end
            out_stall <= stall_now;
        end
    end

    always @(posedge clk)
    begin : check
        wwpc_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: para %0d count %0d total %0b last %0b",
                             paragraph_number, word_count, is_total, last_result);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (paragraph_number !== want.paragraph_number ||
                    word_count !== want.word_count ||
                    is_total !== want.is_total ||
                    last_result !== want.last_result)
                begin
                    if (mismatches < 10)
                        $display({"result mismatch: expected para %0d count %0d total %0b ",
                                  "last %0b, got para %0d count %0d total %0b last %0b"},
                                 want.paragraph_number, want.word_count, want.is_total,
                                 want.last_result, paragraph_number, word_count,
                                 is_total, last_result);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_whole_word_paragraph_counter_unit failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [wwpc_pkg::WORD_W-1:0] word;
        logic [wwpc_pkg::WORD_W-1:0] len_data;
        int unsigned                 added;
        int unsigned                 phase_bytes;
        bit                          paused;
        target_mirror = '0;
        length_mirror = 4'd1;
        restart_text();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at reset: target is a single zero byte
        push_beat(8'h00, 1'b1, 1'b0);
        wait_idle();

        // length zero acts as one; all-ones byte, letter after rejects, end of text accepts
        write_reg(wwpc_pkg::REG_TARGET_WORD, 64'h0123_4567_89AB_CDFF);
        write_reg(wwpc_pkg::REG_TARGET_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
        push_beat(8'hFF, 1'b0, 1'b0);
        push_beat("a", 1'b0, 1'b0);
        push_beat(" ", 1'b0, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b0);
        wait_idle();

        // start of text, overlapping newline pairs, letter before, end of text
        write_reg(wwpc_pkg::REG_TARGET_WORD, 64'h5A5A_5A5A_5A74_6163);
        write_reg(wwpc_pkg::REG_TARGET_LENGTH, 64'h0000_0000_0000_0003);
        push_str("cat\n\n\nAcat cat");
        wait_idle();

        // newline target: paragraph closed on the last byte hides the final one
        write_reg(wwpc_pkg::REG_TARGET_WORD, 64'h0000_0000_0000_000A);
        write_reg(wwpc_pkg::REG_TARGET_LENGTH, 64'h0000_0000_0000_0001);
        push_str(" \n\n");
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            word = {$urandom, $urandom};
            for (int j = 0; j < WORD_MAX; j++)
                word[8*j +: 8] = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 0))
                                                             : random_letter();
            len_data = {$urandom, $urandom};
            case (p)
                0: len_data[wwpc_pkg::LEN_W-1:0] = 4'd1;
                1: len_data[wwpc_pkg::LEN_W-1:0] = 4'd8;
                2: len_data[wwpc_pkg::LEN_W-1:0] = 4'd15;
                3: len_data[wwpc_pkg::LEN_W-1:0] = 4'd0;
                4: len_data[wwpc_pkg::LEN_W-1:0] = 4'd9;
                5: len_data[wwpc_pkg::LEN_W-1:0] = wwpc_pkg::LEN_W'($urandom_range(7, 2));
                6:
                begin
                    len_data[wwpc_pkg::LEN_W-1:0] = 4'd3;
                    word[7:0] = wwpc_pkg::CHAR_NEWLINE;
                end
                default: len_data[wwpc_pkg::LEN_W-1:0] = wwpc_pkg::LEN_W'($urandom_range(15, 0));
            endcase
            write_reg(wwpc_pkg::REG_TARGET_WORD, word);
            write_reg(wwpc_pkg::REG_TARGET_LENGTH, len_data);

            phase_bytes = 0;
            paused = 1'b0;
            while (phase_bytes < PHASE_BYTES)
            begin
                // one forced drain halfway through phase four
                add_text(12, ($urandom_range(99, 0) == 0) ||
                             (p == 4 && !paused && phase_bytes >= PHASE_BYTES / 2), added);
                if (p == 4 && phase_bytes >= PHASE_BYTES / 2)
                    paused = 1'b1;
                phase_bytes += added;
            end
            if (p == 2)
            begin
                while (outgoing.size() > phase_bytes - 40)
                    @(negedge clk);
                hold_req = ~hold_req;
            end
            wait_idle();
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_whole_word_paragraph_counter_unit passed");
        else
            $display("tb_whole_word_paragraph_counter_unit failed");
        $finish;
    end

endmodule
